@@ design/thdc_pkg.sv @@
// Shared types, constants and lookup tables for the thermometer display controller.
package thdc_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int SAMPLE_W   = 8;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_PRESS  = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        LEVEL_LOW  = 2'd0,
        LEVEL_MED  = 2'd1,
        LEVEL_HIGH = 2'd2,
        LEVEL_RSVD = 2'd3
    } t_level;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;

    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 8'd76;
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 8'd51;

    localparam logic [7:0] DEGREE_CODE = 8'h63;
    localparam logic [7:0] DP_BIT      = 8'h80;
    localparam logic [NUM_DIGITS-1:0] MSD_SELECT = 4'b1000;

    // digit positions at which the unit glyph / decimal point appear
    localparam logic [IDX_W-1:0] DEGREE_POS = 2'd3;
    localparam logic [IDX_W-1:0] DP_POS     = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [1:0]            level;
        logic [7:0]            segments;
        logic [NUM_DIGITS-1:0] digit_select;
        logic                  scan_valid;
        logic                  unit_is_celsius;
    } t_out;

    // position 0 is the most significant digit
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digits;
    typedef t_digits [255:0] t_digit_table;

    // Hex seven-segment patterns, index 0 at the right.
    localparam logic [15:0][7:0] SEG_TABLE = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // Sample-to-digit tables, evaluated at elaboration.
    // Celsius: (4s+5)/10 as hundreds, tens, ones, then 0.
    // Fahrenheit: (72s+3205)/10 in tenths as four digits.
    function automatic t_digit_table build_digit_table(input logic celsius);
        t_digit_table tbl;
        int           s;
        int           v;
        tbl = '0;
        for (s = 0; s < 256; s++) begin
            if (celsius) begin
                v = (4 * s + 5) / 10;
                tbl[s][0] = 4'((v / 100) % 10);
                tbl[s][1] = 4'((v / 10) % 10);
                tbl[s][2] = 4'(v % 10);
                tbl[s][3] = 4'd0;
            end else begin
                v = (72 * s + 3205) / 10;
                tbl[s][0] = 4'((v / 1000) % 10);
                tbl[s][1] = 4'((v / 100) % 10);
                tbl[s][2] = 4'((v / 10) % 10);
                tbl[s][3] = 4'(v % 10);
            end
        end
        return tbl;
    endfunction

    localparam t_digit_table CELSIUS_TABLE    = build_digit_table(1'b1);
    localparam t_digit_table FAHRENHEIT_TABLE = build_digit_table(1'b0);

endpackage

@@ design/thdc_level.sv @@
// Three-level temperature indicator compare against the two thresholds.
module thdc_level (
    input  logic [thdc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [thdc_pkg::SAMPLE_W-1:0] i_high_threshold,
    input  logic [thdc_pkg::SAMPLE_W-1:0] i_low_threshold,
    output thdc_pkg::t_level              o_level
);

    always_comb begin
        if (i_sample > i_high_threshold) begin
            o_level = thdc_pkg::LEVEL_HIGH;
        end else if (i_sample >= i_low_threshold) begin
            o_level = thdc_pkg::LEVEL_MED;
        end else begin
            o_level = thdc_pkg::LEVEL_LOW;
        end
    end

endmodule

@@ design/thdc_digits.sv @@
// Sample to display digits in the selected unit, by constant table lookup.
module thdc_digits (
    input  logic [thdc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_celsius,
    output thdc_pkg::t_digits             o_digits
);

    always_comb begin
        if (i_celsius) begin
            o_digits = thdc_pkg::CELSIUS_TABLE[i_sample];
        end else begin
            o_digits = thdc_pkg::FAHRENHEIT_TABLE[i_sample];
        end
    end

endmodule

@@ design/thdc_scan.sv @@
// Segment pattern and one-hot digit select for one scan position.
module thdc_scan (
    input  thdc_pkg::t_digits                    i_digits,
    input  logic [thdc_pkg::IDX_W-1:0]           i_idx,
    input  logic                                 i_celsius,
    output logic [7:0]                           o_segments,
    output logic [thdc_pkg::NUM_DIGITS-1:0]      o_select
);

    logic [7:0] seg_raw;

    assign seg_raw = thdc_pkg::SEG_TABLE[i_digits[i_idx]];

    always_comb begin
        if (i_celsius && (i_idx == thdc_pkg::DEGREE_POS)) begin
            o_segments = thdc_pkg::DEGREE_CODE;
        end else if (!i_celsius && (i_idx == thdc_pkg::DP_POS)) begin
            o_segments = seg_raw | thdc_pkg::DP_BIT;
        end else begin
            o_segments = seg_raw;
        end
    end

    assign o_select = thdc_pkg::MSD_SELECT >> i_idx;

endmodule

@@ design/thermometer_display_controller_top.sv @@
// Top level of the multiplexed seven-segment thermometer display controller.
// Each input transaction is a converter sample, a unit button press or a
// display scan tick, and each one yields exactly one output transaction.
// A sample sets the low/medium/high indicator against the two threshold
// registers and refreshes the four stored digits (Celsius with a degree
// glyph, or Fahrenheit in tenths with a decimal point). A press toggles the
// unit, which starts at Celsius after reset, and redraws the digits from the
// last sample. A scan tick drives the segments and one-hot select of the
// next digit, most significant first. Rate: one transaction per clock unless
// the output stalls; the output register takes the result on acceptance, and
// the input stays ready while that register is empty or being drained this
// cycle. The digit conversion is a 256-entry constant table lookup, so all
// work fits between the state registers and the output register. Threshold
// writes are taken every cycle and update the indicator from the last sample
// at once; write them only while no transaction is in flight.
module thermometer_display_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample / press / tick channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  thdc_pkg::t_in                   i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output thdc_pkg::t_out                  o_out_data,
    // threshold register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [thdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [thdc_pkg::SAMPLE_W-1:0]   i_cfg_data
);

    // ---------------- state ----------------
    logic [thdc_pkg::SAMPLE_W-1:0] r_high_threshold;
    logic [thdc_pkg::SAMPLE_W-1:0] r_low_threshold;
    logic                          r_celsius;
    thdc_pkg::t_digits             r_digits;
    logic [thdc_pkg::IDX_W-1:0]    r_scan_idx;
    thdc_pkg::t_level              r_level;
    logic [thdc_pkg::SAMPLE_W-1:0] r_last_sample;

    logic                          r_out_valid;
    thdc_pkg::t_out                r_out_data;

    // ---------------- handshakes ----------------
    logic in_accept;
    logic cfg_accept;
    logic is_sample;
    logic is_press;
    logic is_tick;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign cfg_accept  = i_cfg_valid;

    assign is_sample = (i_in_data.kind == thdc_pkg::KIND_SAMPLE);
    assign is_press  = (i_in_data.kind == thdc_pkg::KIND_PRESS);
    assign is_tick   = (i_in_data.kind == thdc_pkg::KIND_TICK);

    // ---------------- next state ----------------
    logic [thdc_pkg::SAMPLE_W-1:0] n_high_threshold;
    logic [thdc_pkg::SAMPLE_W-1:0] n_low_threshold;
    logic [thdc_pkg::SAMPLE_W-1:0] n_last_sample;
    logic                          n_celsius;
    thdc_pkg::t_level              n_level;
    thdc_pkg::t_level              cmp_level;
    thdc_pkg::t_digits             conv_digits;
    logic [7:0]                    scan_segments;
    logic [thdc_pkg::NUM_DIGITS-1:0] scan_select;
    thdc_pkg::t_out                n_out_data;

    always_comb begin
        n_high_threshold = r_high_threshold;
        n_low_threshold  = r_low_threshold;
        if (cfg_accept) begin
            case (i_cfg_index)
                thdc_pkg::CFG_HIGH_THRESHOLD: begin
                    n_high_threshold = i_cfg_data;
                end
                thdc_pkg::CFG_LOW_THRESHOLD: begin
                    n_low_threshold = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_last_sample = (in_accept && is_sample) ? i_in_data.sample_value : r_last_sample;
    assign n_celsius     = (in_accept && is_press) ? !r_celsius : r_celsius;

    // One compare serves both sample updates and threshold writes.
    thdc_level u_level (
        .i_sample         (n_last_sample),
        .i_high_threshold (n_high_threshold),
        .i_low_threshold  (n_low_threshold),
        .o_level          (cmp_level)
    );

    // level only moves on a sample or a threshold write that hits a register
    logic level_update;
    assign level_update = (in_accept && is_sample)
        || (cfg_accept && ((i_cfg_index == thdc_pkg::CFG_HIGH_THRESHOLD)
                        || (i_cfg_index == thdc_pkg::CFG_LOW_THRESHOLD)));
    assign n_level = level_update ? cmp_level : r_level;

    // Digits follow the new sample or the new unit.
    thdc_digits u_digits (
        .i_sample  (n_last_sample),
        .i_celsius (n_celsius),
        .o_digits  (conv_digits)
    );

    thdc_scan u_scan (
        .i_digits   (r_digits),
        .i_idx      (r_scan_idx),
        .i_celsius  (r_celsius),
        .o_segments (scan_segments),
        .o_select   (scan_select)
    );

    always_comb begin
        n_out_data.level           = n_level;
        n_out_data.unit_is_celsius = n_celsius;
        if (is_tick) begin
            n_out_data.segments     = scan_segments;
            n_out_data.digit_select = scan_select;
            n_out_data.scan_valid   = 1'b1;
        end else begin
            n_out_data.segments     = '0;
            n_out_data.digit_select = '0;
            n_out_data.scan_valid   = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_threshold <= thdc_pkg::HIGH_THRESHOLD_RST;
            r_low_threshold  <= thdc_pkg::LOW_THRESHOLD_RST;
            r_celsius        <= 1'b1;
            r_digits         <= '0;
            r_scan_idx       <= '0;
            r_level          <= thdc_pkg::LEVEL_LOW;
            r_last_sample    <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_high_threshold <= n_high_threshold;
            r_low_threshold  <= n_low_threshold;
            r_level          <= n_level;
            r_last_sample    <= n_last_sample;
            r_celsius        <= n_celsius;
            if (in_accept && (is_sample || is_press)) begin
                r_digits <= conv_digits;
            end
            if (in_accept && is_tick) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // a scan result lights exactly one digit
    a_scan_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.scan_valid) |-> $onehot(o_out_data.digit_select))
        else $error("scan result select not one-hot");

    // each accepted tick advances the scan position by one
    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_tick) |=> (r_scan_idx == $past(r_scan_idx) + 1'b1))
        else $error("scan index did not advance");

    // last Celsius position shows the degree glyph
    a_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.scan_valid && o_out_data.unit_is_celsius
         && (o_out_data.digit_select == 4'b0001))
        |-> (o_out_data.segments == thdc_pkg::DEGREE_CODE))
        else $error("degree glyph missing");

    // indicator never holds the reserved code
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level != thdc_pkg::LEVEL_RSVD)
        else $error("level register out of range");
`endif

endmodule

@@ sim/tb_thermometer_display_controller_top.sv @@
// Self-checking testbench for the thermometer display controller top level.
`timescale 1ns / 100ps

module tb_thermometer_display_controller_top;

    // Config indexes outside the register map; writes there must be dropped.
    localparam logic [thdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [thdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Hex seven-segment codes, index = digit value.
    localparam logic [7:0] SEG_CODES [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    localparam int MAX_REPORTS = 10;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    thdc_pkg::t_in                  i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    thdc_pkg::t_out                 o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [thdc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [thdc_pkg::SAMPLE_W-1:0]  i_cfg_data  = '0;

    thermometer_display_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Display predictor state: mirrors what the block should hold.
    // ------------------------------------------------------------------
    logic [thdc_pkg::SAMPLE_W-1:0] thr_high     = thdc_pkg::HIGH_THRESHOLD_RST;
    logic [thdc_pkg::SAMPLE_W-1:0] thr_low      = thdc_pkg::LOW_THRESHOLD_RST;
    logic                          unit_celsius = 1'b1;
    logic [thdc_pkg::DIGIT_W-1:0]  digit_q [thdc_pkg::NUM_DIGITS];
    logic [thdc_pkg::IDX_W-1:0]    scan_pos     = '0;
    thdc_pkg::t_level              level_now    = thdc_pkg::LEVEL_LOW;
    logic [thdc_pkg::SAMPLE_W-1:0] last_sample  = '0;

    // Results still owed by the block, oldest first.
    thdc_pkg::t_out pending_display [$];

    int mismatch_count  = 0;
    int sender_idle_pct = 0;   // chance per cycle that the sender holds back
    int stall_pct       = 0;   // chance per cycle that the receiver stalls
    int hold_left       = 0;   // forced receiver hold-off, in cycles

    initial begin
        foreach (digit_q[i]) digit_q[i] = '0;
    end

    function automatic void recompute_level();
        if (last_sample > thr_high)
            level_now = thdc_pkg::LEVEL_HIGH;
        else if (last_sample >= thr_low)
            level_now = thdc_pkg::LEVEL_MED;
        else
            level_now = thdc_pkg::LEVEL_LOW;
    endfunction

    // Celsius rounds 0.4*s; Fahrenheit is 0.72*s + 32.05 degrees, in tenths.
    function automatic void refresh_digits();
        int v;
        if (unit_celsius) begin
            v = (4 * int'(last_sample) + 5) / 10;
            digit_q[0] = 4'((v / 100) % 10);
            digit_q[1] = 4'((v / 10) % 10);
            digit_q[2] = 4'(v % 10);
            digit_q[3] = 4'd0;
        end else begin
            v = (72 * int'(last_sample) + 3205) / 10;
            digit_q[0] = 4'((v / 1000) % 10);
            digit_q[1] = 4'((v / 100) % 10);
            digit_q[2] = 4'((v / 10) % 10);
            digit_q[3] = 4'(v % 10);
        end
    endfunction

    function automatic thdc_pkg::t_out predict_display(input thdc_pkg::t_in item);
        thdc_pkg::t_out             r;
        logic [thdc_pkg::IDX_W-1:0] pos;
        r = '0;
        case (item.kind)
            thdc_pkg::KIND_SAMPLE: begin
                last_sample = item.sample_value;
                recompute_level();
                refresh_digits();
            end
            thdc_pkg::KIND_PRESS: begin
                unit_celsius = ~unit_celsius;
                refresh_digits();
            end
            thdc_pkg::KIND_TICK: begin
                pos = scan_pos;
                r.segments = SEG_CODES[digit_q[pos]];
                // degree glyph replaces the last digit in Celsius;
                // decimal point only in Fahrenheit
                if (unit_celsius && pos == thdc_pkg::DEGREE_POS)
                    r.segments = thdc_pkg::DEGREE_CODE;
                else if (!unit_celsius && pos == thdc_pkg::DP_POS)
                    r.segments = r.segments | thdc_pkg::DP_BIT;
                r.digit_select = thdc_pkg::MSD_SELECT >> pos;
                r.scan_valid   = 1'b1;
                scan_pos       = pos + 1'b1;
            end
            default: ;  // unused kind: no state change
        endcase
        r.level           = level_now;
        r.unit_is_celsius = unit_celsius;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted output transaction against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        thdc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_display.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result lvl %0d seg %02h sel %b scan %b unit %b",
                    o_out_data.level, o_out_data.segments, o_out_data.digit_select,
                    o_out_data.scan_valid, o_out_data.unit_is_celsius));
            end else begin
                want = pending_display.pop_front();
                if (o_out_data !== want)
                    note_failure($sformatf({
                        "result mismatch exp lvl %0d seg %02h sel %b scan %b unit %b,",
                        " got lvl %0d seg %02h sel %b scan %b unit %b"},
                        want.level, want.segments, want.digit_select, want.scan_valid,
                        want.unit_is_celsius, o_out_data.level, o_out_data.segments,
                        o_out_data.digit_select, o_out_data.scan_valid,
                        o_out_data.unit_is_celsius));
            end
        end
    end

    // Receiver side: random stalls, plus a forced hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Offer one transaction; returns right after the accepting edge with
    // valid still high, so the next call can keep the stream back to back.
    task automatic send_item(input thdc_pkg::t_kind kind,
                             input logic [thdc_pkg::SAMPLE_W-1:0] value);
        thdc_pkg::t_in item;
        item.kind         = kind;
        item.sample_value = value;
        @(negedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_display.push_back(predict_display(item));
    endtask

    // Stop offering and wait for every owed result, plus the output
    // register latency.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_display.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register write; only called with the block drained.
    task automatic write_reg(input logic [thdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [thdc_pkg::SAMPLE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            thdc_pkg::CFG_HIGH_THRESHOLD: thr_high = val;
            thdc_pkg::CFG_LOW_THRESHOLD:  thr_low  = val;
            default: ;  // out-of-range index is dropped
        endcase
        if (idx == thdc_pkg::CFG_HIGH_THRESHOLD || idx == thdc_pkg::CFG_LOW_THRESHOLD)
            recompute_level();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic reset_dut();
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Reset digits, a full-scale sample in both units, a zero sample in
    // Fahrenheit, the unused kind, and samples straddling both reset thresholds.
    task automatic test_directed_display();
        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (4) send_item(thdc_pkg::KIND_TICK, 8'h00);   // reset digits, degree glyph
        send_item(thdc_pkg::KIND_SAMPLE, 8'hFF);             // 102 C
        repeat (4) send_item(thdc_pkg::KIND_TICK, 8'hA5);
        send_item(thdc_pkg::KIND_PRESS, 8'h5A);              // redraw as 215.6 F
        repeat (4) send_item(thdc_pkg::KIND_TICK, 8'h00);
        send_item(thdc_pkg::KIND_SAMPLE, 8'h00);             // 32.0 F
        repeat (4) send_item(thdc_pkg::KIND_TICK, 8'hFF);
        send_item(thdc_pkg::KIND_UNUSED, 8'hFF);
        send_item(thdc_pkg::KIND_PRESS, 8'h00);              // back to Celsius
        send_item(thdc_pkg::KIND_SAMPLE, 8'd77);             // just above high
        send_item(thdc_pkg::KIND_SAMPLE, 8'd76);             // at high -> medium
        send_item(thdc_pkg::KIND_SAMPLE, 8'd51);             // at low -> medium
        send_item(thdc_pkg::KIND_SAMPLE, 8'd50);             // just below low
        drain_results();
    endtask

    // Threshold extremes, including an inverted pair, and the spare
    // indexes that must not disturb anything.
    task automatic test_threshold_settings();
        logic [thdc_pkg::SAMPLE_W-1:0] hi_set [4] = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        logic [thdc_pkg::SAMPLE_W-1:0] lo_set [4] = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        for (int k = 0; k < 4; k++) begin
            write_reg(thdc_pkg::CFG_HIGH_THRESHOLD, hi_set[k]);
            write_reg(thdc_pkg::CFG_LOW_THRESHOLD, lo_set[k]);
            send_item(thdc_pkg::KIND_UNUSED, 8'h00);         // level from last sample
            send_item(thdc_pkg::KIND_SAMPLE, 8'h00);
            send_item(thdc_pkg::KIND_SAMPLE, 8'h01);
            send_item(thdc_pkg::KIND_SAMPLE, 8'hFE);
            send_item(thdc_pkg::KIND_SAMPLE, 8'hFF);
            drain_results();
        end
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h00);
        write_reg(thdc_pkg::CFG_HIGH_THRESHOLD, thdc_pkg::HIGH_THRESHOLD_RST);
        write_reg(thdc_pkg::CFG_LOW_THRESHOLD, thdc_pkg::LOW_THRESHOLD_RST);
        send_item(thdc_pkg::KIND_SAMPLE, 8'd60);
        drain_results();
    endtask

    // New random thresholds between traffic phases.
    task automatic retune_thresholds();
        logic [thdc_pkg::SAMPLE_W-1:0] a;
        logic [thdc_pkg::SAMPLE_W-1:0] b;
        a = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        // mostly an ordered pair, sometimes inverted
        if ($urandom_range(3) != 0 && a < b) begin
            write_reg(thdc_pkg::CFG_HIGH_THRESHOLD, b);
            write_reg(thdc_pkg::CFG_LOW_THRESHOLD, a);
        end else begin
            write_reg(thdc_pkg::CFG_HIGH_THRESHOLD, a);
            write_reg(thdc_pkg::CFG_LOW_THRESHOLD, b);
        end
        if ($urandom_range(1) != 0)
            write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                      8'($urandom_range(255)));
    endtask

    // Random mix weighted toward samples and scan ticks so digits in both
    // units are read back often; sample values cluster at the extremes
    // and around the thresholds.
    task automatic test_random_traffic(input int count, input int idle, input int stall);
        int                            r;
        thdc_pkg::t_kind               kind;
        logic [thdc_pkg::SAMPLE_W-1:0] value;
        sender_idle_pct = idle;
        stall_pct       = stall;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 35)
                kind = thdc_pkg::KIND_SAMPLE;
            else if (r < 43)
                kind = thdc_pkg::KIND_PRESS;
            else if (r < 94)
                kind = thdc_pkg::KIND_TICK;
            else
                kind = thdc_pkg::KIND_UNUSED;
            r = $urandom_range(99);
            if (r < 8) begin
                value = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            end else if (r < 25) begin
                case ($urandom_range(3))
                    0:       value = thr_low;
                    1:       value = thr_low - 8'd1;
                    2:       value = thr_high;
                    default: value = thr_high + 8'd1;
                endcase
            end else begin
                value = 8'($urandom_range(255));
            end
            send_item(kind, value);
        end
        drain_results();
    endtask

    // Receiver held off for a long stretch while the sender keeps
    // offering: the output register fills and the input must stall.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct       = 0;
        @(posedge i_clk);
        hold_left = 80;
        for (int n = 0; n < 30; n++)
            send_item((n % 3 == 0) ? thdc_pkg::KIND_SAMPLE : thdc_pkg::KIND_TICK,
                      8'($urandom_range(255)));
        // sender pauses here until every result is back
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_dut();
        test_directed_display();
        test_threshold_settings();
        test_random_traffic(190, 0, 0);     // full rate both sides
        retune_thresholds();
        test_random_traffic(190, 79, 0);    // sparse sender
        retune_thresholds();
        test_random_traffic(190, 0, 79);    // slow receiver
        retune_thresholds();
        test_random_traffic(190, 19, 19);   // light gaps both sides
        test_backpressure();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_display.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ thermometer_display_controller_top.f @@
design/thdc_pkg.sv
design/thdc_level.sv
design/thdc_digits.sv
design/thdc_scan.sv
design/thermometer_display_controller_top.sv
sim/tb_thermometer_display_controller_top.sv
